/* src/ahpc_pkg.sv */
// Shared types, codes and reset constants of the arm homing position controller.
package ahpc_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_BITS        = 3;
    localparam int SPEED_BITS            = 7;
    localparam int DEADBAND_BITS         = 10;
    localparam int BRAKE_BITS            = 8;

    localparam logic [SPEED_BITS-1:0]    SPEED_FULL       = 7'd100;
    localparam logic [SPEED_BITS-1:0]    COMPARE_STOPPED  = 7'd100;
    localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET   = 10'd15;
    localparam logic [SPEED_BITS-1:0]    MIN_SPEED_RESET  = 7'd15;
    localparam logic [SPEED_BITS-1:0]    MAX_SPEED_RESET  = 7'd50;
    localparam logic [SPEED_BITS-1:0]    HOME_SPEED_RESET = 7'd20;
    localparam logic [BRAKE_BITS-1:0]    BRAKE_TICKS_RESET = 8'd20;
    localparam logic [BRAKE_BITS-1:0]    BRAKE_COUNT_MAX  = 8'd255;
    localparam int                       HOME_TARGET_RESET = 256;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_SET  = 2'd1,
        MODE_HOME = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        HOME_NOT  = 2'd0,
        HOME_SEEK = 2'd1,
        HOME_DONE = 2'd2
    } t_home;

    typedef enum logic [1:0] {
        MOT_IDLE  = 2'd0,
        MOT_MOVE  = 2'd1,
        MOT_BRAKE = 2'd2
    } t_motion;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RIGHT_ARM    = 3'd0,
        CFG_DEADBAND     = 3'd1,
        CFG_MIN_SPEED    = 3'd2,
        CFG_MAX_SPEED    = 3'd3,
        CFG_HOMING_SPEED = 3'd4,
        CFG_BRAKE_TICKS  = 3'd5,
        CFG_HOME_TARGET  = 3'd6
    } t_cfg_idx;

    // Saturate a speed to full scale and turn it into a timer compare value.
    function automatic logic [SPEED_BITS-1:0] speed_to_compare(input logic [SPEED_BITS-1:0] spd);
        logic [SPEED_BITS-1:0] sat;
        sat = (spd > SPEED_FULL) ? SPEED_FULL : spd;
        return COMPARE_STOPPED - sat;
    endfunction

endpackage

/* src/arm_homing_position_controller.sv */
// Top level of the arm homing position controller: state update and result register.
//
// Position controller for one arm motor. Each accepted input word (a control tick, a
// set-target command or a start-homing command) yields exactly one result word that
// reports the drive compare value, the direction pin, the brake, an encoder-zero pulse
// and the homing and motion status. The whole state update is a single combinational
// pass from the input port into the state registers and the result register, so a new
// word can be taken every cycle unless o_stall is raised; the result appears in the cycle
// after acceptance and stays in the result register until taken. While a result is
// waiting and the downstream side stalls, o_stall is raised toward the upstream side.
// Homing drives down at homing speed until the back limit closes, then pulses
// o_zero_encoder, loads the home target and starts moving. While moving, speed is
// |error|/4 clamped to [min_speed, max_speed]; inside the deadband the drive stops,
// the brake is applied on the following ticks for brake_ticks ticks, then the
// controller goes idle. Write configuration only while no word is in flight.
module arm_homing_position_controller #(
    parameter int POSITION_BITS = ahpc_pkg::POSITION_BITS_DEFAULT,
    parameter int CFG_DATA_BITS = (POSITION_BITS > ahpc_pkg::DEADBAND_BITS)
                                  ? POSITION_BITS : ahpc_pkg::DEADBAND_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [ahpc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]            i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_mode,
    input  logic signed [POSITION_BITS-1:0]     i_encoder_count,
    input  logic                                i_limit_back,
    input  logic signed [POSITION_BITS-1:0]     i_target_value,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ahpc_pkg::SPEED_BITS-1:0]     o_pwm_compare,
    output logic                                o_direction_pin,
    output logic                                o_brake_engaged,
    output logic                                o_zero_encoder,
    output logic [1:0]                          o_home_status,
    output logic [1:0]                          o_motion_status
);
    import ahpc_pkg::*;

    localparam int ERR_BITS = POSITION_BITS + 2;
    localparam int MAG_BITS = ERR_BITS - 2;

    // configuration registers
    logic                             r_right_arm;
    logic [DEADBAND_BITS-1:0]         r_deadband;
    logic [SPEED_BITS-1:0]            r_min_speed;
    logic [SPEED_BITS-1:0]            r_max_speed;
    logic [SPEED_BITS-1:0]            r_homing_speed;
    logic [BRAKE_BITS-1:0]            r_brake_ticks;
    logic signed [POSITION_BITS-1:0]  r_home_target;

    // controller state
    t_home                            r_home, n_home;
    t_motion                          r_motion, n_motion;
    logic signed [POSITION_BITS-1:0]  r_target, n_target;
    logic                             r_drive_up, n_drive_up;
    logic [SPEED_BITS-1:0]            r_held_cmp, n_held_cmp;
    logic                             r_brake_on, n_brake_on;
    logic [BRAKE_BITS-1:0]            r_brake_cnt, n_brake_cnt;
    logic                             n_zero;

    // result register
    logic                             r_out_valid;
    logic [SPEED_BITS-1:0]            r_out_cmp;
    logic                             r_out_dir;
    logic                             r_out_brake;
    logic                             r_out_zero;
    logic [1:0]                       r_out_home;
    logic [1:0]                       r_out_motion;

    logic                             in_accept;
    logic                             out_take;

    // position error path
    logic signed [ERR_BITS-1:0]       actual;
    logic signed [ERR_BITS-1:0]       err;
    logic signed [ERR_BITS-1:0]       db_pos;
    logic [ERR_BITS-1:0]              err_abs;
    logic [MAG_BITS-1:0]              mag;
    logic [MAG_BITS-1:0]              mag_lo;
    logic [MAG_BITS-1:0]              mag_clamped;
    logic [BRAKE_BITS-1:0]            brake_inc;

    assign out_take  = r_out_valid & ~i_stall;
    // Hold upstream only while a finished result still waits downstream.
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_arm    <= 1'b0;
            r_deadband     <= DEADBAND_RESET;
            r_min_speed    <= MIN_SPEED_RESET;
            r_max_speed    <= MAX_SPEED_RESET;
            r_homing_speed <= HOME_SPEED_RESET;
            r_brake_ticks  <= BRAKE_TICKS_RESET;
            r_home_target  <= POSITION_BITS'(HOME_TARGET_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RIGHT_ARM:    r_right_arm    <= i_cfg_data[0];
                CFG_DEADBAND:     r_deadband     <= i_cfg_data[DEADBAND_BITS-1:0];
                CFG_MIN_SPEED:    r_min_speed    <= i_cfg_data[SPEED_BITS-1:0];
                CFG_MAX_SPEED:    r_max_speed    <= i_cfg_data[SPEED_BITS-1:0];
                CFG_HOMING_SPEED: r_homing_speed <= i_cfg_data[SPEED_BITS-1:0];
                CFG_BRAKE_TICKS:  r_brake_ticks  <= i_cfg_data[BRAKE_BITS-1:0];
                CFG_HOME_TARGET:  r_home_target  <= i_cfg_data[POSITION_BITS-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Error and speed: left arm counts negated encoder position.
    always_comb begin
        actual  = r_right_arm ? ERR_BITS'(i_encoder_count) : -ERR_BITS'(i_encoder_count);
        err     = ERR_BITS'(r_target) - actual;
        db_pos  = ERR_BITS'({1'b0, r_deadband});
        err_abs = err[ERR_BITS-1] ? ERR_BITS'(-err) : ERR_BITS'(err);
        // truncation toward zero of err/4 has the magnitude |err| >> 2
        mag     = err_abs[ERR_BITS-1:2];
        mag_lo  = (mag < MAG_BITS'(r_min_speed)) ? MAG_BITS'(r_min_speed) : mag;
        mag_clamped = (mag_lo > MAG_BITS'(r_max_speed)) ? MAG_BITS'(r_max_speed) : mag_lo;
        brake_inc = (r_brake_cnt < BRAKE_COUNT_MAX) ? r_brake_cnt + BRAKE_BITS'(1)
                                                    : r_brake_cnt;
    end

    // Next state for one accepted word.
    always_comb begin
        n_home      = r_home;
        n_motion    = r_motion;
        n_target    = r_target;
        n_drive_up  = r_drive_up;
        n_held_cmp  = r_held_cmp;
        n_brake_on  = r_brake_on;
        n_brake_cnt = r_brake_cnt;
        n_zero      = 1'b0;

        unique case (t_mode'(i_mode))
            MODE_SET: begin
                n_target   = i_target_value;
                n_brake_on = 1'b0;
                n_motion   = MOT_MOVE;
            end
            MODE_HOME: begin
                n_home = HOME_SEEK;
            end
            MODE_TICK: begin
                if (r_home == HOME_SEEK) begin
                    n_brake_on = 1'b0;
                    n_drive_up = 1'b0;
                    if (i_limit_back) begin
                        n_zero     = 1'b1;
                        n_held_cmp = COMPARE_STOPPED;
                        n_target   = r_home_target;
                        n_motion   = MOT_MOVE;
                        n_home     = HOME_DONE;
                    end else begin
                        n_held_cmp = speed_to_compare(r_homing_speed);
                    end
                end else if (r_home == HOME_DONE) begin
                    if (r_motion == MOT_MOVE) begin
                        if (err > db_pos) begin
                            n_drive_up = 1'b1;
                            n_held_cmp = speed_to_compare(mag_clamped[SPEED_BITS-1:0]);
                            n_brake_on = 1'b0;
                        end else if (err < -db_pos) begin
                            n_drive_up = 1'b0;
                            n_held_cmp = speed_to_compare(mag_clamped[SPEED_BITS-1:0]);
                            n_brake_on = 1'b0;
                        end else begin
                            n_held_cmp  = COMPARE_STOPPED;
                            n_motion    = MOT_BRAKE;
                            n_brake_cnt = '0;
                        end
                    end else if (r_motion == MOT_BRAKE) begin
                        n_held_cmp  = COMPARE_STOPPED;
                        n_brake_on  = 1'b1;
                        n_brake_cnt = brake_inc;
                        if (brake_inc >= r_brake_ticks) begin
                            n_motion = MOT_IDLE;
                        end
                    end else begin
                        n_held_cmp = COMPARE_STOPPED;
                        n_brake_on = 1'b0;
                    end
                end
            end
            default: begin
                // unused mode: hold everything
            end
        endcase
    end

    // State update on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home      <= HOME_NOT;
            r_motion    <= MOT_IDLE;
            r_target    <= '0;
            r_drive_up  <= 1'b1;
            r_held_cmp  <= COMPARE_STOPPED;
            r_brake_on  <= 1'b0;
            r_brake_cnt <= '0;
        end else if (in_accept) begin
            r_home      <= n_home;
            r_motion    <= n_motion;
            r_target    <= n_target;
            r_drive_up  <= n_drive_up;
            r_held_cmp  <= n_held_cmp;
            r_brake_on  <= n_brake_on;
            r_brake_cnt <= n_brake_cnt;
        end
    end

    // Result valid: set on accept, clear when taken with nothing new behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: load with the state this word leaves behind.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_cmp    <= n_held_cmp;
            r_out_dir    <= r_right_arm ? ~n_drive_up : n_drive_up;
            r_out_brake  <= n_brake_on;
            r_out_zero   <= n_zero;
            r_out_home   <= n_home;
            r_out_motion <= n_motion;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pwm_compare   = r_out_cmp;
    assign o_direction_pin = r_out_dir;
    assign o_brake_engaged = r_out_brake;
    assign o_zero_encoder  = r_out_zero;
    assign o_home_status   = r_out_home;
    assign o_motion_status = r_out_motion;

endmodule
